// File: rtl/mte_pkg.sv
// ----------------------------------------------------------------------------
// mte_pkg
// Shared types and codes for the multiset table engine.
// ----------------------------------------------------------------------------
package mte_pkg;

  localparam int unsigned DefCapacity   = 64;
  localparam int unsigned DefValueWidth = 32;

  localparam int unsigned OpW     = 3;
  localparam int unsigned PortValW = 32;
  localparam int unsigned DrawW   = 16;
  localparam int unsigned AnsW    = 32;
  localparam int unsigned StatW   = 2;
  localparam int unsigned OccW    = 7;

  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 48;

  typedef enum logic [OpW-1:0] {
    OP_INSERT    = 3'd0,
    OP_ERASE_ONE = 3'd1,
    OP_ERASE_ALL = 3'd2,
    OP_COUNT     = 3'd3,
    OP_GRAB      = 3'd4
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Broadcast command to every cell of the chain.
  typedef struct packed {
    logic push;      // every cell takes its upper neighbor, cell 0 takes the new value
    logic drop;      // remove the entry under the token, head fills the hole
    logic tok_load;  // place the token at the given index
    logic tok_step;  // token moves one cell away from the head
  } mte_ctl_t;

endpackage

// File: rtl/mte_cell.sv
// ----------------------------------------------------------------------------
// mte_cell
// One entry of the chain. Cell 0 holds the head; a scan token walks down.
// ----------------------------------------------------------------------------
module mte_cell
  import mte_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = DefValueWidth,
  parameter int unsigned IDX_W       = 6,
  parameter int unsigned IDX         = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mte_ctl_t               ctl_i,
  input  logic [IDX_W-1:0]       tok_idx_i,
  input  logic [VALUE_WIDTH-1:0] up_val_i,
  input  logic [VALUE_WIDTH-1:0] down_val_i,
  input  logic [VALUE_WIDTH-1:0] head_val_i,
  input  logic                   tok_up_i,
  input  logic                   tok_down_i,
  input  logic [VALUE_WIDTH-1:0] target_i,
  output logic [VALUE_WIDTH-1:0] val_o,
  output logic                   tok_o,
  output logic                   hit_o
);

  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic                   tok_q, tok_d;

  always_comb begin
    val_d = val_q;
    if (ctl_i.push) begin
      val_d = up_val_i;
    end else if (ctl_i.drop) begin
      // The cell just above the hole receives the old head; the rest move up.
      val_d = tok_down_i ? head_val_i : down_val_i;
    end
  end

  always_comb begin
    tok_d = tok_q;
    if (ctl_i.tok_load) begin
      tok_d = (tok_idx_i == IDX_W'(IDX));
    end else if (ctl_i.tok_step) begin
      tok_d = tok_up_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign val_o = val_q;
  assign tok_o = tok_q;
  assign hit_o = tok_q && (val_q == target_i);

endmodule

// File: rtl/mte_mod.sv
// ----------------------------------------------------------------------------
// mte_mod
// Bit-serial restoring remainder: dividend mod divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module mte_mod
  import mte_pkg::*;
#(
  parameter int unsigned CNT_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DrawW-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic             done_o,
  output logic [CNT_W-1:0] rem_o
);

  localparam int unsigned BitCntW = $clog2(DrawW);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [BitCntW-1:0] bit_q, bit_d;
  logic [DrawW-1:0]   num_q, num_d;
  logic [CNT_W-1:0]   div_q, div_d;
  logic [CNT_W:0]     rem_q, rem_d;
  logic [CNT_W:0]     trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    bit_d  = bit_q;
    num_d  = num_q;
    div_d  = div_q;
    rem_d  = rem_q;
    trial  = {rem_q[CNT_W-1:0], num_q[DrawW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      bit_d  = BitCntW'(DrawW - 1);
      num_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      num_d = {num_q[DrawW-2:0], 1'b0};
      rem_d = (trial >= {1'b0, div_q}) ? trial - {1'b0, div_q} : trial;
      bit_d = bit_q - 1'b1;
      if (bit_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      bit_q  <= bit_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[CNT_W-1:0];

endmodule

// File: rtl/multiset_table_engine.sv
// ----------------------------------------------------------------------------
// multiset_table_engine
// Bounded multiset held in a chain of cells, head at cell 0.
// ----------------------------------------------------------------------------
// Usage: commands arrive as beats on the s_axis channel and each produces
// exactly one result beat on the m_axis channel. Insert pushes the value into
// the head cell; erase, erase-all and count walk a token down the chain, one
// cell per cycle except while an erase drops a hit and the token stays put.
// Grab runs a bit-serial remainder (draw mod occupancy), then reads the cell
// under the token. The token walk over the cells is what sets the scan cost.
// One command is processed at a time; s_axis_tready_o is high whenever the
// engine is idle, even while the last result still waits on m_axis.
// If the receiver stalls, a finished result waits in its state until the
// output register frees, and no further command is accepted meanwhile.
// Reset empties the store (occupancy zero) and clears the m_axis valid.
// ----------------------------------------------------------------------------
module multiset_table_engine
  import mte_pkg::*;
#(
  parameter int unsigned CAPACITY    = DefCapacity,
  parameter int unsigned VALUE_WIDTH = DefValueWidth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [2:0] opcode, [34:3] value, [50:35] random_draw, [55:51] zero
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [31:0] answer, [33:32] status, [40:34] occupancy, [47:41] zero
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DIV,
    S_GRAB,
    S_DONE
  } state_e;

  state_e                 state_q, state_d;
  logic [CntW-1:0]        fill_q, fill_d;
  logic [CntW-1:0]        idx_q, idx_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [OpW-1:0]         op_q, op_d;
  logic [VALUE_WIDTH-1:0] tgt_q, tgt_d;
  logic [AnsW-1:0]        ans_q, ans_d;
  status_e                stat_q, stat_d;
  logic                   ovalid_q, ovalid_d;
  logic [AnsW-1:0]        oans_q, oans_d;
  logic [StatW-1:0]       ostat_q, ostat_d;
  logic [OccW-1:0]        oocc_q, oocc_d;

  mte_ctl_t         ctl;
  logic [IdxW-1:0]  tok_idx;
  logic             div_start;
  logic             div_done;
  logic [CntW-1:0]  div_rem;

  logic                   in_fire;
  logic [OpW-1:0]         in_op;
  logic [VALUE_WIDTH-1:0] in_val;
  logic [DrawW-1:0]       in_draw;

  logic [VALUE_WIDTH-1:0] vals [CAPACITY];
  logic                   toks [CAPACITY];
  logic                   hits [CAPACITY];
  logic                   any_hit;
  logic [VALUE_WIDTH-1:0] tok_val;

  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign in_op   = s_axis_tdata_i[OpW-1:0];
  assign in_val  = VALUE_WIDTH'(64'(s_axis_tdata_i[OpW +: PortValW]));
  assign in_draw = s_axis_tdata_i[OpW+PortValW +: DrawW];

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [VALUE_WIDTH-1:0] up_val, down_val;
    logic                   tok_up, tok_down;
    if (k == 0) begin : g_first
      assign up_val = in_val;
      assign tok_up = 1'b0;
    end else begin : g_mid
      assign up_val = vals[k-1];
      assign tok_up = toks[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign down_val = '0;
      assign tok_down = 1'b0;
    end else begin : g_nlast
      assign down_val = vals[k+1];
      assign tok_down = toks[k+1];
    end
    mte_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .IDX_W       (IdxW),
      .IDX         (k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .tok_idx_i  (tok_idx),
      .up_val_i   (up_val),
      .down_val_i (down_val),
      .head_val_i (vals[0]),
      .tok_up_i   (tok_up),
      .tok_down_i (tok_down),
      .target_i   (tgt_q),
      .val_o      (vals[k]),
      .tok_o      (toks[k]),
      .hit_o      (hits[k])
    );
  end

  // The token is one-hot, so an OR over the chain picks the cell under it.
  always_comb begin
    any_hit = 1'b0;
    tok_val = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      any_hit = any_hit | hits[k];
      tok_val = tok_val | (toks[k] ? vals[k] : '0);
    end
  end

  mte_mod #(
    .CNT_W (CntW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_draw),
    .divisor_i  (fill_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    op_d      = op_q;
    tgt_d     = tgt_q;
    ans_d     = ans_q;
    stat_d    = stat_q;
    ovalid_d  = ovalid_q;
    oans_d    = oans_q;
    ostat_d   = ostat_q;
    oocc_d    = oocc_q;
    ctl       = '0;
    tok_idx   = '0;
    div_start = 1'b0;

    if (ovalid_q && m_axis_tready_i) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d   = in_op;
          tgt_d  = in_val;
          ans_d  = '0;
          stat_d = ST_OK;
          cnt_d  = '0;
          idx_d  = '0;
          state_d = S_DONE;
          case (in_op)
            OP_INSERT: begin
              if (fill_q == CntW'(CAPACITY)) begin
                stat_d = ST_FULL;
              end else begin
                ctl.push = 1'b1;
                fill_d   = fill_q + 1'b1;
              end
            end
            OP_ERASE_ONE, OP_ERASE_ALL, OP_COUNT: begin
              ctl.tok_load = 1'b1;
              state_d      = S_SCAN;
            end
            OP_GRAB: begin
              if (fill_q == '0) begin
                stat_d = ST_EMPTY;
              end else begin
                div_start = 1'b1;
                state_d   = S_DIV;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (idx_q >= fill_q) begin
          if (op_q == OP_ERASE_ONE) begin
            stat_d = ST_NOT_FOUND;
          end else begin
            ans_d = AnsW'(cnt_q);
          end
          state_d = S_DONE;
        end else if (op_q == OP_COUNT) begin
          cnt_d        = cnt_q + CntW'(any_hit);
          idx_d        = idx_q + 1'b1;
          ctl.tok_step = 1'b1;
        end else if (any_hit) begin
          ctl.drop = 1'b1;
          fill_d   = fill_q - 1'b1;
          cnt_d    = cnt_q + 1'b1;
          if (op_q == OP_ERASE_ONE) begin
            state_d = S_DONE;
          end
        end else begin
          idx_d        = idx_q + 1'b1;
          ctl.tok_step = 1'b1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          ctl.tok_load = 1'b1;
          tok_idx      = div_rem[IdxW-1:0];
          state_d      = S_GRAB;
        end
      end
      S_GRAB: begin
        ans_d   = AnsW'(64'(tok_val));
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!ovalid_q || m_axis_tready_i) begin
          ovalid_d = 1'b1;
          oans_d   = ans_q;
          ostat_d  = stat_q;
          oocc_d   = OccW'(fill_q);
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    cnt_q   <= cnt_d;
    op_q    <= op_d;
    tgt_q   <= tgt_d;
    ans_q   <= ans_d;
    stat_q  <= stat_d;
    oans_q  <= oans_d;
    ostat_q <= ostat_d;
    oocc_q  <= oocc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fill_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {7'd0, oocc_q, ostat_q, oans_q};

endmodule

// File: verif/tb_multiset_table_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multiset_table_engine
// Drives random and directed multiset commands into the engine, predicts each
// result with a behavioral bag model and compares answer, status and occupancy.
// ----------------------------------------------------------------------------
module tb_multiset_table_engine;
  import mte_pkg::*;

  localparam int unsigned Cap = DefCapacity;
  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned HoldCycles = 200;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [OutDataW-1:0] m_axis_tdata_o;

  typedef struct packed {
    logic [AnsW-1:0]  answer;
    status_e          status;
    logic [OccW-1:0]  occupancy;
  } bag_result_t;

  logic [31:0] bag_slots [Cap];
  int unsigned bag_fill;
  bag_result_t pending_results [$];
  int unsigned error_count;
  int unsigned idle_cycles;
  bit          hold_off;
  bit          sending_done;

  multiset_table_engine u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Slot bag_fill-1 is the head; position p sits in slot bag_fill-1-p.
  function automatic bag_result_t apply_bag_command(logic [2:0] op, logic [31:0] val,
                                                    logic [15:0] draw);
    bag_result_t r;
    int unsigned n;
    r.answer = '0;
    r.status = ST_OK;
    case (op)
      OP_INSERT: begin
        if (bag_fill >= Cap) r.status = ST_FULL;
        else begin
          bag_slots[bag_fill] = val;
          bag_fill++;
        end
      end
      OP_ERASE_ONE: begin
        r.status = ST_NOT_FOUND;
        for (int i = bag_fill; i > 0; i--) begin
          if (bag_slots[i-1] == val) begin
            bag_slots[i-1] = bag_slots[bag_fill-1];
            bag_fill--;
            r.status = ST_OK;
            break;
          end
        end
      end
      OP_ERASE_ALL: begin
        n = 0;
        for (int i = bag_fill; i > 0; i--) begin
          if (bag_slots[i-1] == val) begin
            bag_slots[i-1] = bag_slots[bag_fill-1];
            bag_fill--;
            n++;
          end
        end
        r.answer = n;
      end
      OP_COUNT: begin
        n = 0;
        for (int i = 0; i < bag_fill; i++) if (bag_slots[i] == val) n++;
        r.answer = n;
      end
      OP_GRAB: begin
        if (bag_fill == 0) r.status = ST_EMPTY;
        else r.answer = bag_slots[bag_fill - 1 - (draw % bag_fill)];
      end
      default: ;
    endcase
    r.occupancy = bag_fill[OccW-1:0];
    return r;
  endfunction

  // Leaves tvalid high after the beat; the next beat or an idle stretch takes it over.
  task automatic send_command(logic [2:0] op, logic [31:0] val, logic [15:0] draw);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {5'b0, draw, val, op};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_results.push_back(apply_bag_command(op, val, draw));
  endtask

  // Bursty sender: a random gap now and then between beats.
  task automatic send_bursty(logic [2:0] op, logic [31:0] val, logic [15:0] draw);
    if ($urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    send_command(op, val, draw);
  endtask

  // Small value pool so that duplicates and hits are common.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h0;
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  task automatic test_directed();
    send_command(OP_GRAB, 32'h0, 16'hFFFF);
    send_command(OP_ERASE_ONE, 32'h5, 16'h0);
    send_command(OP_ERASE_ALL, 32'h5, 16'h0);
    send_command(OP_COUNT, 32'h5, 16'h0);
    send_command(OP_INSERT, 32'h0, 16'h0);
    send_command(OP_INSERT, 32'hFFFF_FFFF, 16'h0);
    send_command(OP_INSERT, 32'h0, 16'h0);
    send_command(OP_INSERT, 32'hA5A5_5A5A, 16'h0);
    send_command(OP_COUNT, 32'h0, 16'h0);
    send_command(OP_GRAB, 32'h0, 16'h0);
    send_command(OP_GRAB, 32'h0, 16'hFFFF);
    send_command(OP_ERASE_ONE, 32'h0, 16'h0);
    send_command(OP_ERASE_ONE, 32'h1234, 16'h0);
    send_command(3'd5, 32'hFFFF_FFFF, 16'hFFFF);
    send_command(3'd6, 32'h0, 16'h0);
    send_command(3'd7, 32'h1, 16'h1);
    send_command(OP_ERASE_ALL, 32'hFFFF_FFFF, 16'h0);
    send_command(OP_ERASE_ALL, 32'h0, 16'h0);
    send_command(OP_ERASE_ALL, 32'hA5A5_5A5A, 16'h0);
  endtask

  // Fill past capacity, then drain with erase-all.
  task automatic test_full_store();
    for (int i = 0; i < Cap + 3; i++) send_bursty(OP_INSERT, i % 3, 16'($urandom()));
    send_command(OP_COUNT, 32'h1, 16'h0);
    send_command(OP_GRAB, 32'h0, 16'hFFFF);
    send_command(OP_ERASE_ALL, 32'h0, 16'h0);
    send_command(OP_ERASE_ALL, 32'h1, 16'h0);
    send_command(OP_ERASE_ALL, 32'h2, 16'h0);
  endtask

  // The receiver holds off for a long stretch while commands keep coming.
  task automatic test_backpressure();
    fork
      begin
        hold_off <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_off <= 1'b0;
      end
    join_none
    for (int i = 0; i < 12; i++) send_command(OP_INSERT, pick_value(), 16'h0);
  endtask

  task automatic test_random(int unsigned n_items);
    logic [2:0] op;
    for (int i = 0; i < n_items; i++) begin
      // Bias toward inserts while small, toward erases while near full.
      if (bag_fill < 8 && $urandom_range(0, 1)) op = OP_INSERT;
      else if (bag_fill > Cap - 4 && $urandom_range(0, 1)) op = OP_ERASE_ALL;
      else op = 3'($urandom_range(0, 7));
      send_bursty(op, pick_value(), 16'($urandom()));
    end
  endtask

  // Receiver stall pattern, plus the long hold-off when asked.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (hold_off) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      bag_result_t got;
      bag_result_t want;
      got = '{answer: m_axis_tdata_o[31:0], status: status_e'(m_axis_tdata_o[33:32]),
              occupancy: m_axis_tdata_o[40:34]};
      if (pending_results.size() == 0) begin
        $error("unexpected result beat %h", m_axis_tdata_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.answer !== want.answer) begin
          $error("answer: expected %0d, got %0d", want.answer, got.answer);
          error_count++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          error_count++;
        end
        if (got.occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
          error_count++;
        end
      end
    end
  end

  // Counts cycles without any accepted beat on either side, outside the hold-off.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)
        || hold_off) begin
      idle_cycles <= 0;
    end else if (!sending_done || pending_results.size() != 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    bag_fill        = 0;
    error_count     = 0;
    idle_cycles     = 0;
    hold_off        = 1'b0;
    sending_done    = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_store();
    test_backpressure();
    s_axis_tvalid_i <= 1'b0;
    repeat (300) @(posedge clk_i);
    test_random(1850);
    s_axis_tvalid_i <= 1'b0;
    sending_done = 1'b1;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
